// ===== design/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants of the Hall angle estimator
// Holds the sector table, the sequencer states, the control bundle between
// the sequencer and the datapath, and the divider request and response types.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

  // Correction spreads the sector error over 2^CorrShift ticks
  localparam int CorrShift = 3;
  localparam int CorrW     = CorrShift + 1;
  localparam logic [CorrW-1:0] CorrInit = CorrW'(1 << CorrShift);

  // Offset added to each sector's table angle on a hall edge (-4000)
  localparam logic [15:0] SectorOffset = 16'hF060;
  // Reset value of the raw period
  localparam logic [15:0] RawPeriodInit = 16'hFFF0;
  // Reset value of the period filter gain
  localparam logic [14:0] FilterGainInit = 15'd32;

  // Divider: 15 quotient bits, saturating at 32767
  localparam int QuotW    = 15;
  localparam int DivSteps = QuotW;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam logic [QuotW-1:0] QuotMax = {QuotW{1'b1}};

  // Motor direction codes
  localparam logic [1:0] DirStop    = 2'd0;
  localparam logic [1:0] DirForward = 2'd1;
  localparam logic [1:0] DirReverse = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] RegDirection  = 3'd0;
  localparam logic [2:0] RegFilterGain = 3'd1;
  localparam logic [2:0] RegStepScale  = 3'd2;
  localparam logic [2:0] RegSpeedScale = 3'd3;
  localparam logic [2:0] RegLockTicks  = 3'd4;
  localparam logic [2:0] RegRampEnd    = 3'd5;
  localparam logic [2:0] RegRampInc    = 3'd6;

  // Input mode codes
  localparam logic ModeHallEdge = 1'b0;
  localparam logic ModeTick     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_STEP,
    ST_WAIT_STEP,
    ST_DIV_SPEED,
    ST_WAIT_SPEED,
    ST_UPDATE,
    ST_OUT
  } hse_state_e;

  typedef struct packed {
    logic in_ready;
    logic mul_en;
    logic acc_en;
    logic div_start;
    logic div_sel_speed;
    logic cap_step;
    logic cap_speed;
    logic upd_en;
    logic out_load;
  } hse_ctl_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] den;
  } hse_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } hse_div_rsp_t;

  // Q15 angle of each Hall code; invalid codes map to zero
  function automatic logic [15:0] hall_table_angle(input logic [2:0] sector);
    logic [15:0] a;
    unique case (sector)
      3'd1:    a = 16'h5555;  // 21845
      3'd2:    a = 16'hAA98;  // -21864
      3'd3:    a = 16'h8000;  // -32768
      3'd5:    a = 16'h2AAA;  // 10922
      3'd6:    a = 16'hD554;  // -10924
      default: a = 16'h0000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== design/hall_sensor_angle_estimator.sv =====
// ----------------------------------------------------------------------------
// hall_sensor_angle_estimator: rotor angle from Hall sector and timer
// Hall edges latch period and sector and set up an angle correction; control
// ticks run open-loop start-up, filter the period, derive step and speed
// through a shared divider and advance the angle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | mode, hall_sector, timer_count
//  out     | output    | out_valid_o/out_ready_i| angle, speed, angle_step,
//          |           |                        | filtered_period, open_loop
//  cfg     | input     | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
//  After an accept, a running tick first runs the filter multiply and
//  accumulate; every item then makes two divider passes (step, then speed),
//  each a start, 15 quotient steps and done, where a saturating quotient
//  skips the steps. The input is not ready until the result is loaded into
//  the output register, and a result still waiting there stalls the next one.
//  Reset is asynchronous and active low; it clears the sequencer, settings,
//  estimator state and output valid, not the work and output data registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_sensor_angle_estimator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  // input items
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               mode_i,
  input  wire logic [2:0]         hall_sector_i,
  input  wire logic [15:0]        timer_count_i,
  // result items
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      angle_o,
  output logic signed [15:0]      speed_o,
  output logic signed [15:0]      angle_step_o,
  output logic [15:0]             filtered_period_o,
  output logic                    open_loop_o
);

  // Configuration registers
  logic [1:0]  direction_q;
  logic [14:0] filter_gain_q;
  logic [31:0] step_scale_q;
  logic [31:0] speed_scale_q;
  logic [15:0] lock_ticks_q;
  logic [15:0] ramp_end_q;
  logic [15:0] ramp_inc_q;

  // Estimator state
  logic [15:0]              hall_angle_q;
  logic [15:0]              corr_step_q;
  logic [hse_pkg::CorrW-1:0] corr_left_q;
  logic [2:0]               sector_q;
  logic [15:0]              raw_period_q;
  logic [31:0]              filter_acc_q;
  logic [15:0]              period_avg_q;
  logic                     in_ol_q;
  logic [15:0]              lock_cnt_q;
  logic [15:0]              ramp_cnt_q;
  logic [15:0]              ol_angle_q;

  // Item work registers
  logic                     run_q;
  logic [15:0]              ang_res_q;
  logic [31:0]              prod_q;
  logic [hse_pkg::QuotW-1:0] q_step_q;
  logic [hse_pkg::QuotW-1:0] q_speed_q;

  // Output registers
  logic                     out_valid_q;
  logic [15:0]              out_angle_q;
  logic [15:0]              out_speed_q;
  logic [15:0]              out_step_q;
  logic [15:0]              out_period_q;
  logic                     out_ol_q;

  hse_pkg::hse_state_e      state_q, state_d;
  hse_pkg::hse_ctl_t        ctl;
  hse_pkg::hse_div_req_t    div_req;
  hse_pkg::hse_div_rsp_t    div_rsp;

  logic                     accept;
  logic                     running;
  logic                     out_free;
  logic [15:0]              hall_err;
  logic [16:0]              ramp_sum;
  logic signed [16:0]       period_diff;
  logic signed [32:0]       product;
  logic [31:0]              acc_next;
  logic [15:0]              step_dir;

  // Apply direction to a saturated quotient
  function automatic logic [15:0] directed(input logic [hse_pkg::QuotW-1:0] q,
                                           input logic [1:0] dir);
    logic [15:0] r;
    case (dir)
      hse_pkg::DirForward: r = {1'b0, q};
      hse_pkg::DirReverse: r = 16'(17'd0 - {2'b0, q});
      default:             r = 16'd0;
    endcase
    return r;
  endfunction

  assign accept   = in_valid_i && ctl.in_ready;
  assign running  = (direction_q == hse_pkg::DirForward) ||
                    (direction_q == hse_pkg::DirReverse);
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hse_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (mode_i == hse_pkg::ModeTick && running) ?
                    hse_pkg::ST_MUL : hse_pkg::ST_DIV_STEP;
        end
      end
      hse_pkg::ST_MUL:        state_d = hse_pkg::ST_ACC;
      hse_pkg::ST_ACC:        state_d = hse_pkg::ST_DIV_STEP;
      hse_pkg::ST_DIV_STEP:   state_d = hse_pkg::ST_WAIT_STEP;
      hse_pkg::ST_WAIT_STEP: begin
        if (div_rsp.done) state_d = hse_pkg::ST_DIV_SPEED;
      end
      hse_pkg::ST_DIV_SPEED:  state_d = hse_pkg::ST_WAIT_SPEED;
      hse_pkg::ST_WAIT_SPEED: begin
        if (div_rsp.done) state_d = hse_pkg::ST_UPDATE;
      end
      hse_pkg::ST_UPDATE:     state_d = hse_pkg::ST_OUT;
      hse_pkg::ST_OUT: begin
        if (out_free) state_d = hse_pkg::ST_IDLE;
      end
      default:                state_d = hse_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: control outputs
  always_comb begin
    ctl = '0;
    unique case (state_q)
      hse_pkg::ST_IDLE:       ctl.in_ready  = 1'b1;
      hse_pkg::ST_MUL:        ctl.mul_en    = 1'b1;
      hse_pkg::ST_ACC:        ctl.acc_en    = 1'b1;
      hse_pkg::ST_DIV_STEP:   ctl.div_start = 1'b1;
      hse_pkg::ST_WAIT_STEP:  ctl.cap_step  = div_rsp.done;
      hse_pkg::ST_DIV_SPEED: begin
        ctl.div_start     = 1'b1;
        ctl.div_sel_speed = 1'b1;
      end
      hse_pkg::ST_WAIT_SPEED: ctl.cap_speed = div_rsp.done;
      hse_pkg::ST_UPDATE:     ctl.upd_en    = 1'b1;
      hse_pkg::ST_OUT:        ctl.out_load  = out_free;
      default:                ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= hse_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q   <= hse_pkg::DirStop;
      filter_gain_q <= hse_pkg::FilterGainInit;
      step_scale_q  <= '0;
      speed_scale_q <= '0;
      lock_ticks_q  <= '0;
      ramp_end_q    <= '0;
      ramp_inc_q    <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hse_pkg::RegDirection:  direction_q   <= cfg_wdata_i[1:0];
        hse_pkg::RegFilterGain: filter_gain_q <= cfg_wdata_i[14:0];
        hse_pkg::RegStepScale:  step_scale_q  <= cfg_wdata_i;
        hse_pkg::RegSpeedScale: speed_scale_q <= cfg_wdata_i;
        hse_pkg::RegLockTicks:  lock_ticks_q  <= cfg_wdata_i[15:0];
        hse_pkg::RegRampEnd:    ramp_end_q    <= cfg_wdata_i[15:0];
        hse_pkg::RegRampInc:    ramp_inc_q    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Combinational helpers for the estimator state
  assign hall_err    = 16'(hse_pkg::hall_table_angle(hall_sector_i) + hse_pkg::SectorOffset
                           - hall_angle_q);
  assign ramp_sum    = {1'b0, ramp_cnt_q} + {1'b0, ramp_inc_q};
  assign period_diff = $signed({1'b0, raw_period_q}) - $signed({1'b0, period_avg_q});
  assign product     = period_diff * $signed({1'b0, filter_gain_q});
  assign acc_next    = filter_acc_q + prod_q;
  assign step_dir    = directed(q_step_q, direction_q);

  // Estimator state: hall edge and start-up on accept, filter, angle advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hall_angle_q <= '0;
      corr_step_q  <= '0;
      corr_left_q  <= '0;
      sector_q     <= '0;
      raw_period_q <= hse_pkg::RawPeriodInit;
      filter_acc_q <= '0;
      period_avg_q <= '0;
      in_ol_q      <= 1'b1;
      lock_cnt_q   <= '0;
      ramp_cnt_q   <= '0;
      ol_angle_q   <= '0;
      run_q        <= 1'b0;
    end else begin
      if (accept) begin
        run_q <= (mode_i == hse_pkg::ModeTick) && running;
        if (mode_i == hse_pkg::ModeHallEdge) begin
          raw_period_q <= timer_count_i;
          sector_q     <= hall_sector_i;
          corr_step_q  <= 16'($signed(hall_err) >>> hse_pkg::CorrShift);
          corr_left_q  <= hse_pkg::CorrInit;
        end else if (running && in_ol_q) begin
          // advance the start-up: lock, then ramp, then leave open loop
          if (lock_cnt_q < lock_ticks_q) begin
            lock_cnt_q <= lock_cnt_q + 16'd1;
          end else if (ramp_cnt_q < ramp_end_q) begin
            ramp_cnt_q <= ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
          end else begin
            in_ol_q <= 1'b0;
          end
          ol_angle_q   <= hse_pkg::hall_table_angle(sector_q);
          hall_angle_q <= hse_pkg::hall_table_angle(sector_q);
        end
      end
      // first-order period filter
      if (ctl.acc_en) begin
        filter_acc_q <= acc_next;
        period_avg_q <= acc_next[30:15];
      end
      // advance the closed-loop angle, folding in one correction share
      if (ctl.upd_en && run_q && !in_ol_q) begin
        if (corr_left_q != '0) begin
          hall_angle_q <= hall_angle_q + step_dir + corr_step_q;
          corr_left_q  <= corr_left_q - 1'b1;
        end else begin
          hall_angle_q <= hall_angle_q + step_dir;
        end
      end
    end
  end

  // Item work registers: result angle, filter product, quotients
  always_ff @(posedge clk_i) begin
    if (accept) ang_res_q <= in_ol_q ? ol_angle_q : hall_angle_q;
    else if (ctl.upd_en && run_q) ang_res_q <= in_ol_q ? ol_angle_q : hall_angle_q;
    if (ctl.mul_en)    prod_q    <= product[31:0];
    if (ctl.cap_step)  q_step_q  <= div_rsp.quot;
    if (ctl.cap_speed) q_speed_q <= div_rsp.quot;
  end

  // Shared divider: step scale first, then speed scale, over the average
  assign div_req.start = ctl.div_start;
  assign div_req.num   = ctl.div_sel_speed ? speed_scale_q : step_scale_q;
  assign div_req.den   = period_avg_q;

  hse_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register: hold the result item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_angle_q  <= ang_res_q;
      out_speed_q  <= directed(q_speed_q, direction_q);
      out_step_q   <= step_dir;
      out_period_q <= period_avg_q;
      out_ol_q     <= in_ol_q;
    end
  end

  assign in_ready_o        = ctl.in_ready;
  assign out_valid_o       = out_valid_q;
  assign angle_o           = $signed(out_angle_q);
  assign speed_o           = $signed(out_speed_q);
  assign angle_step_o      = $signed(out_step_q);
  assign filtered_period_o = out_period_q;
  assign open_loop_o       = out_ol_q;

  // An accepted item keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // The divider reports only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == hse_pkg::ST_WAIT_STEP ||
                      state_q == hse_pkg::ST_WAIT_SPEED))
    else $error("divider done outside a wait state");

  // Correction count never exceeds its initial value
  a_corr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corr_left_q <= hse_pkg::CorrInit)
    else $error("correction count out of range");

  // Open loop ends only on an accepted item
  a_ol_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ol_q) |-> $past(accept))
    else $error("open loop left outside an accepted tick");

  // A result is loaded only into a free output register
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

endmodule

`default_nettype wire

// ===== design/hse_divider.sv =====
// ----------------------------------------------------------------------------
// hse_divider: iterative saturating 32/16 divider
// Restoring division, one quotient bit per cycle. A quotient that would not
// fit in 15 bits, or a zero divisor, returns 32767 in the cycle after start.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_divider (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire hse_pkg::hse_div_req_t req_i,
  output hse_pkg::hse_div_rsp_t      rsp_o
);

  logic [15:0]                  rem_q, rem_d;
  logic [15:0]                  den_q;
  logic [hse_pkg::QuotW-1:0]    num_lo_q;
  logic [hse_pkg::QuotW-1:0]    quot_q;
  logic [hse_pkg::DivCntW-1:0]  cnt_q;
  logic                         busy_q;
  logic                         done_q;
  logic [16:0]                  trial;
  logic                         trial_ge;
  logic                         sat;

  // Quotient overflows when the top 17 bits already reach the divisor
  assign sat = (req_i.num[31:hse_pkg::QuotW] >= {1'b0, req_i.den});

  // One restoring step: shift in the next dividend bit and try a subtract
  assign trial    = {rem_q, num_lo_q[hse_pkg::QuotW-1]};
  assign trial_ge = (trial >= {1'b0, den_q});
  assign rem_d    = trial_ge ? 16'(trial - {1'b0, den_q}) : trial[15:0];

  // Control: busy flag, step count, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= !sat;
        done_q <= sat;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == hse_pkg::DivCntW'(hse_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, dividend shift, quotient shift
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q    <= req_i.num[30:hse_pkg::QuotW];
      num_lo_q <= req_i.num[hse_pkg::QuotW-1:0];
      den_q    <= req_i.den;
      quot_q   <= hse_pkg::QuotMax;
    end else if (busy_q) begin
      rem_q    <= rem_d;
      num_lo_q <= {num_lo_q[hse_pkg::QuotW-2:0], 1'b0};
      quot_q   <= {quot_q[hse_pkg::QuotW-2:0], trial_ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

// ===== tb/hse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_checker: result predictor and comparator for the Hall angle estimator
// Watches the configuration port and both item channels, keeps its own copy
// of the estimator state, predicts one result per accepted input item and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module hse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        mode_i,
  input  logic [2:0]  hall_sector_i,
  input  logic [15:0] timer_count_i,
  // result channel
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] angle_i,
  input  logic [15:0] speed_i,
  input  logic [15:0] angle_step_i,
  input  logic [15:0] filtered_period_i,
  input  logic        open_loop_i,
  // status toward the testbench top
  output int          fail_count_o,
  output int          pending_o
);

  // Correction is spread over 2^CorrBits ticks
  localparam int          CorrBits   = 3;
  localparam logic [3:0]  CorrTicks  = 4'd8;
  // Offset on the sector target angle, -4000
  localparam logic [15:0] EdgeOffset = 16'hF060;
  localparam logic [15:0] RateLimit  = 16'd32767;
  localparam int          ReportMax  = 10;

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] speed;
    logic [15:0] angle_step;
    logic [15:0] filtered_period;
    logic        open_loop;
  } est_result_t;

  // Configuration copy
  logic [1:0]  dir_q;
  logic [14:0] gain_q;
  logic [31:0] step_scale_q;
  logic [31:0] speed_scale_q;
  logic [15:0] lock_ticks_q;
  logic [15:0] ramp_end_q;
  logic [15:0] ramp_inc_q;

  // Estimator state copy
  logic [15:0] hall_ang;
  logic [15:0] corr_step;
  logic [3:0]  corr_left;
  logic [2:0]  sector;
  logic [15:0] raw_per;
  logic [31:0] filt_acc;
  logic [15:0] per_avg;
  logic        in_ol;
  logic [15:0] lock_cnt;
  logic [15:0] ramp_cnt;
  logic [15:0] ol_ang;

  est_result_t estimates_due[$];
  est_result_t seen;
  est_result_t want;

  // Q15 angle of each Hall code; the two invalid codes sit at zero
  function automatic logic [15:0] hall_code_angle(input logic [2:0] code);
    case (code)
      3'd1:    return 16'd21845;
      3'd2:    return 16'hAA98;   // -21864
      3'd3:    return 16'h8000;   // -32768
      3'd5:    return 16'd10922;
      3'd6:    return 16'hD554;   // -10924
      default: return 16'd0;
    endcase
  endfunction

  // Saturating scale / filtered period, signed by direction
  function automatic logic [15:0] rate_quotient(input logic [31:0] scale);
    logic [31:0] q;
    logic [15:0] r;
    if (per_avg == 16'd0) begin
      r = RateLimit;
    end else begin
      q = scale / {16'd0, per_avg};
      r = (q > {16'd0, RateLimit}) ? RateLimit : q[15:0];
    end
    if (dir_q == hse_pkg::DirForward) return r;
    if (dir_q == hse_pkg::DirReverse) return 16'd0 - r;
    return 16'd0;
  endfunction

  // Advance the state copy by one input item and form its result
  function automatic est_result_t estimate_angle(input logic m, input logic [2:0] code,
                                                 input logic [15:0] count);
    est_result_t      res;
    logic [15:0]      used;
    logic [15:0]      target;
    logic signed [15:0] err_s;
    logic [15:0]      step_v;
    logic [31:0]      ramp_sum;
    longint           raw_l;
    longint           avg_l;
    longint           gain_l;
    longint           diff;
    logic             running;

    used    = in_ol ? ol_ang : hall_ang;
    running = (dir_q == hse_pkg::DirForward) || (dir_q == hse_pkg::DirReverse);

    if (m == hse_pkg::ModeHallEdge) begin
      raw_per   = count;
      sector    = code;
      target    = hall_code_angle(code) + EdgeOffset;
      err_s     = target - hall_ang;
      corr_step = err_s >>> CorrBits;
      corr_left = CorrTicks;
    end else if (running) begin
      // open-loop start-up: lock, ramp, then hand over
      if (in_ol) begin
        if (lock_cnt < lock_ticks_q) begin
          lock_cnt = lock_cnt + 16'd1;
        end else if (ramp_cnt < ramp_end_q) begin
          ramp_sum = {16'd0, ramp_cnt} + {16'd0, ramp_inc_q};
          ramp_cnt = (ramp_sum > 32'h0000_FFFF) ? 16'hFFFF : ramp_sum[15:0];
        end else begin
          in_ol = 1'b0;
        end
        ol_ang   = hall_code_angle(sector);
        hall_ang = ol_ang;
      end

      // first-order period filter, accumulator wraps at 32 bits
      raw_l    = raw_per;
      avg_l    = per_avg;
      gain_l   = gain_q;
      diff     = (raw_l - avg_l) * gain_l;
      filt_acc = filt_acc + diff[31:0];
      per_avg  = filt_acc[30:15];

      step_v = rate_quotient(step_scale_q);
      if (in_ol) begin
        used = ol_ang;
      end else begin
        used     = hall_ang;
        hall_ang = hall_ang + step_v;
        if (corr_left != 4'd0) begin
          hall_ang  = hall_ang + corr_step;
          corr_left = corr_left - 4'd1;
        end
      end
    end

    res.angle           = used;
    res.speed           = rate_quotient(speed_scale_q);
    res.angle_step      = rate_quotient(step_scale_q);
    res.filtered_period = per_avg;
    res.open_loop       = in_ol;
    return res;
  endfunction

  // Track writes, predict accepted items, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q         = hse_pkg::DirStop;
      gain_q        = 15'd32;
      step_scale_q  = 32'd0;
      speed_scale_q = 32'd0;
      lock_ticks_q  = 16'd0;
      ramp_end_q    = 16'd0;
      ramp_inc_q    = 16'd1;
      hall_ang      = 16'd0;
      corr_step     = 16'd0;
      corr_left     = 4'd0;
      sector        = 3'd0;
      raw_per       = 16'hFFF0;
      filt_acc      = 32'd0;
      per_avg       = 16'd0;
      in_ol         = 1'b1;
      lock_cnt      = 16'd0;
      ramp_cnt      = 16'd0;
      ol_ang        = 16'd0;
      estimates_due.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hse_pkg::RegDirection:  dir_q         = cfg_wdata_i[1:0];
          hse_pkg::RegFilterGain: gain_q        = cfg_wdata_i[14:0];
          hse_pkg::RegStepScale:  step_scale_q  = cfg_wdata_i;
          hse_pkg::RegSpeedScale: speed_scale_q = cfg_wdata_i;
          hse_pkg::RegLockTicks:  lock_ticks_q  = cfg_wdata_i[15:0];
          hse_pkg::RegRampEnd:    ramp_end_q    = cfg_wdata_i[15:0];
          hse_pkg::RegRampInc:    ramp_inc_q    = cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        estimates_due.push_back(estimate_angle(mode_i, hall_sector_i, timer_count_i));
      end

      if (out_valid_i && out_ready_i) begin
        seen.angle           = angle_i;
        seen.speed           = speed_i;
        seen.angle_step      = angle_step_i;
        seen.filtered_period = filtered_period_i;
        seen.open_loop       = open_loop_i;
        if (estimates_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportMax) begin
            $display("%0t: result with nothing expected", $realtime);
            $display("%0t:          act angle=%h speed=%h step=%h period=%h ol=%b",
                     $realtime, seen.angle, seen.speed, seen.angle_step,
                     seen.filtered_period, seen.open_loop);
          end
        end else begin
          want = estimates_due.pop_front();
          if (seen != want) begin
            fail_count_o++;
            if (fail_count_o <= ReportMax) begin
              $display("%0t: mismatch exp angle=%h speed=%h step=%h period=%h ol=%b",
                       $realtime, want.angle, want.speed, want.angle_step,
                       want.filtered_period, want.open_loop);
              $display("%0t:          act angle=%h speed=%h step=%h period=%h ol=%b",
                       $realtime, seen.angle, seen.speed, seen.angle_step,
                       seen.filtered_period, seen.open_loop);
            end
          end
        end
      end

      pending_o = estimates_due.size();
    end
  end

endmodule

// ===== tb/hall_sensor_angle_estimator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_sensor_angle_estimator_tb: stimulus and verdict for the angle estimator
// Runs a directed start-up sequence through lock, ramp and closed loop, then
// phases of random Hall rotations and control ticks under random settings,
// with bursty input, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------

module hall_sensor_angle_estimator_tb;

  localparam int         HalfPeriod  = 5;
  localparam int         ResetCycles = 12;
  localparam int         StallLimit  = 3000;
  localparam int         HoldCycles  = 400;
  localparam int         EndCycles   = 60;
  localparam int         RandPhases  = 8;
  localparam int         PhaseItems  = 50;
  localparam int         HoldPhase   = 3;
  localparam logic [1:0] DirUndef    = 2'd3;

  // Receiver stall patterns
  localparam int PatAlways = 0;
  localparam int PatCoin   = 1;
  localparam int PatSparse = 2;
  localparam int PatBlocks = 3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = hse_pkg::RegDirection;
  logic [31:0] cfg_wdata_i   = 32'd0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic        mode_i        = hse_pkg::ModeHallEdge;
  logic [2:0]  hall_sector_i = 3'd0;
  logic [15:0] timer_count_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic signed [15:0] angle_o;
  logic signed [15:0] speed_o;
  logic signed [15:0] angle_step_o;
  logic [15:0] filtered_period_o;
  logic        open_loop_o;

  logic        in_acc_q  = 1'b0;
  logic        out_acc_q = 1'b0;
  logic        hold_go   = 1'b0;
  int          fail_count;
  int          pending;
  int          burst_left;
  logic [31:0] cfg_set [7];

  hall_sensor_angle_estimator u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .hall_sector_i     (hall_sector_i),
    .timer_count_i     (timer_count_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .angle_o           (angle_o),
    .speed_o           (speed_o),
    .angle_step_o      (angle_step_o),
    .filtered_period_o (filtered_period_o),
    .open_loop_o       (open_loop_o)
  );

  hse_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .mode_i            (mode_i),
    .hall_sector_i     (hall_sector_i),
    .timer_count_i     (timer_count_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .angle_i           (angle_o),
    .speed_i           (speed_o),
    .angle_step_i      (angle_step_o),
    .filtered_period_i (filtered_period_o),
    .open_loop_i       (open_loop_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Record handshakes at the rising edge for the falling-edge drivers
  always @(posedge clk_i) begin
    in_acc_q  <= in_valid_i && in_ready_o;
    out_acc_q <= out_valid_o && out_ready_i;
  end

  // Hall codes in order of rising table angle
  function automatic logic [2:0] rotation_code(input int pos);
    case (pos)
      0:       return 3'd4;
      1:       return 3'd5;
      2:       return 3'd1;
      3:       return 3'd3;
      4:       return 3'd2;
      default: return 3'd6;
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom >> $urandom_range(4, 20);
    endcase
  endfunction

  // Offer one item, hold it until accepted, then maybe open a gap
  task automatic send_item(input logic m, input logic [2:0] code, input logic [15:0] count);
    int gap;
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    hall_sector_i <= code;
    timer_count_i <= count;
    do @(negedge clk_i); while (!in_acc_q);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 9);
      if (gap < 3) gap = 0;
      else if (gap < 8) gap = $urandom_range(1, 4);
      else gap = $urandom_range(5, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Drop valid and wait until every result is out
  task automatic wait_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write all registers from cfg_set, one per cycle
  task automatic apply_config();
    for (int i = int'(hse_pkg::RegDirection); i <= int'(hse_pkg::RegRampInc); i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[2:0];
      cfg_wdata_i <= cfg_set[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: stall patterns in random stretches, one long hold-off
  initial begin : receiver
    int   stretch_left;
    int   pattern;
    int   phase_cnt;
    logic hold_taken;
    logic rdy;
    stretch_left = 0;
    pattern      = PatAlways;
    phase_cnt    = 0;
    hold_taken   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (stretch_left == 0) begin
        pattern      = $urandom_range(PatAlways, PatBlocks);
        stretch_left = $urandom_range(20, 200);
      end
      stretch_left--;
      phase_cnt++;
      case (pattern)
        PatAlways: rdy = 1'b1;
        PatCoin:   rdy = 1'($urandom_range(0, 1));
        PatSparse: rdy = (phase_cnt % 4) == 0;
        default:   rdy = (phase_cnt % 24) >= 16;
      endcase
      out_ready_i <= rdy;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(negedge clk_i);
      if (!rst_ni || in_acc_q || out_acc_q) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("hall_sensor_angle_estimator_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int          seq_pos;
    int          ticks_left;
    int          period;
    int          count;
    int          r;
    logic        reverse;
    burst_left = 1;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: stopped, so ticks change nothing; invalid codes
    send_item(hse_pkg::ModeHallEdge, 3'd0, 16'd0);
    send_item(hse_pkg::ModeTick, 3'd7, 16'hFFFF);
    send_item(hse_pkg::ModeHallEdge, 3'd7, 16'hFFFF);
    wait_idle();

    // Forward start-up: lock, ramp into saturation, zero filter gain
    cfg_set[hse_pkg::RegDirection]  = 32'(hse_pkg::DirForward);
    cfg_set[hse_pkg::RegFilterGain] = 32'd0;
    cfg_set[hse_pkg::RegStepScale]  = 32'hFFFF_FFFF;
    cfg_set[hse_pkg::RegSpeedScale] = 32'd0;
    cfg_set[hse_pkg::RegLockTicks]  = 32'd2;
    cfg_set[hse_pkg::RegRampEnd]    = 32'd65535;
    cfg_set[hse_pkg::RegRampInc]    = 32'd40000;
    apply_config();
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    send_item(hse_pkg::ModeHallEdge, 3'd1, 16'd1000);
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    send_item(hse_pkg::ModeHallEdge, 3'd3, 16'hFFFF);
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    wait_idle();

    // Closed loop in reverse with full filter gain
    cfg_set[hse_pkg::RegDirection]  = 32'(hse_pkg::DirReverse);
    cfg_set[hse_pkg::RegFilterGain] = 32'd32767;
    cfg_set[hse_pkg::RegStepScale]  = 32'd5000000;
    cfg_set[hse_pkg::RegSpeedScale] = 32'hFFFF_FFFF;
    cfg_set[hse_pkg::RegLockTicks]  = 32'd0;
    cfg_set[hse_pkg::RegRampEnd]    = 32'd0;
    cfg_set[hse_pkg::RegRampInc]    = 32'd65535;
    apply_config();
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    send_item(hse_pkg::ModeHallEdge, 3'd2, 16'd0);
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    send_item(hse_pkg::ModeHallEdge, 3'd5, 16'd43690);
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    send_item(hse_pkg::ModeHallEdge, 3'd6, 16'd21845);
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    wait_idle();

    // Undefined direction code, then stopped
    cfg_set[hse_pkg::RegDirection] = 32'(DirUndef);
    apply_config();
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    send_item(hse_pkg::ModeHallEdge, 3'd4, 16'd12345);
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    wait_idle();
    cfg_set[hse_pkg::RegDirection] = 32'(hse_pkg::DirStop);
    apply_config();
    send_item(hse_pkg::ModeTick, 3'd0, 16'd0);
    wait_idle();

    // Random phases: rotations with ticks in between, some noise
    for (int p = 0; p < RandPhases; p++) begin
      r = $urandom_range(0, 19);
      if (r < 9) cfg_set[hse_pkg::RegDirection] = 32'(hse_pkg::DirForward);
      else if (r < 17) cfg_set[hse_pkg::RegDirection] = 32'(hse_pkg::DirReverse);
      else if (r == 17) cfg_set[hse_pkg::RegDirection] = 32'(hse_pkg::DirStop);
      else cfg_set[hse_pkg::RegDirection] = 32'(DirUndef);
      case ($urandom_range(0, 4))
        0:       cfg_set[hse_pkg::RegFilterGain] = 32'd0;
        1:       cfg_set[hse_pkg::RegFilterGain] = 32'd32767;
        2:       cfg_set[hse_pkg::RegFilterGain] = 32'd32;
        default: cfg_set[hse_pkg::RegFilterGain] = $urandom_range(0, 32767);
      endcase
      cfg_set[hse_pkg::RegStepScale]  = rand_scale();
      cfg_set[hse_pkg::RegSpeedScale] = rand_scale();
      cfg_set[hse_pkg::RegLockTicks]  = $urandom_range(0, 65535);
      cfg_set[hse_pkg::RegRampEnd]    = $urandom_range(0, 65535);
      cfg_set[hse_pkg::RegRampInc]    = $urandom_range(1, 65535);
      apply_config();

      reverse    = (cfg_set[hse_pkg::RegDirection] == 32'(hse_pkg::DirReverse));
      period     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(100, 8000);
      seq_pos    = $urandom_range(0, 5);
      ticks_left = $urandom_range(2, 12);

      for (int k = 0; k < PhaseItems; k++) begin
        if (p == HoldPhase && k == 5) hold_go <= 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          send_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    16'($urandom_range(0, 65535)));
        end else if (ticks_left == 0) begin
          seq_pos = reverse ? (seq_pos + 5) % 6 : (seq_pos + 1) % 6;
          count   = period + $urandom_range(0, period / 8);
          if (count > 65535) count = 65535;
          send_item(hse_pkg::ModeHallEdge, rotation_code(seq_pos), 16'(count));
          ticks_left = $urandom_range(2, 12);
        end else begin
          send_item(hse_pkg::ModeTick, 3'($urandom), 16'($urandom));
          ticks_left--;
        end
      end
      wait_idle();
    end

    repeat (EndCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("hall_sensor_angle_estimator_tb: clean");
    end else begin
      $display("hall_sensor_angle_estimator_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hse_pkg.sv
design/hse_divider.sv
design/hall_sensor_angle_estimator.sv
tb/hse_checker.sv
tb/hall_sensor_angle_estimator_tb.sv
